@@ src/fxalu_pkg.sv @@
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared types and constants for the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 8;
  localparam int unsigned QuotW    = DataW + FracBits;
  localparam int unsigned NumCells = QuotW;
  localparam int unsigned MagW     = DataW;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_INC = 4'd4, OP_DEC = 4'd5, OP_MIN = 4'd6, OP_MAX = 4'd7,
    OP_GT  = 4'd8, OP_LT  = 4'd9, OP_GE  = 4'd10, OP_LE = 4'd11,
    OP_EQ  = 4'd12, OP_NE = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
  } op_t;

  // One beat travelling down the row of cells.
  typedef struct packed {
    logic                      valid;
    logic                      is_div;
    logic                      neg;
    logic                      dz;
    logic [DataW-1:0]          res;
    logic                      cmp;
    logic [MagW:0]             rem;
    logic [QuotW-1:0]          num;
    logic [MagW-1:0]           den;
  } lane_t;

endpackage

@@ src/fxalu_front.sv @@
// ----------------------------------------------------------------------------
// fxalu_front
// Decodes one beat: all non-divide operations, plus divide set-up.
// Multiply result is registered here; divide runs in the cell row.
// ----------------------------------------------------------------------------
module fxalu_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [3:0]                     operation,
  input  logic signed [fxalu_pkg::DataW-1:0] operand_a,
  input  logic signed [fxalu_pkg::DataW-1:0] operand_b,
  output fxalu_pkg::lane_t               lane
);
  import fxalu_pkg::*;

  op_t               op;
  logic [MagW-1:0]   mag_a;
  logic [MagW-1:0]   mag_b;
  logic              neg;
  logic [2*MagW-1:0] prod;
  logic [DataW-1:0]  pmag;
  logic [DataW-1:0]  res_c;
  logic              cmp_c;
  lane_t             lane_next;

  assign op    = op_t'(operation);
  assign mag_a = operand_a[DataW-1] ? (~operand_a + 1'b1) : operand_a;
  assign mag_b = operand_b[DataW-1] ? (~operand_b + 1'b1) : operand_b;
  assign neg   = operand_a[DataW-1] ^ operand_b[DataW-1];
  assign prod  = mag_a * mag_b;
  assign pmag  = prod[FracBits +: DataW];

  always_comb begin
    res_c = '0;
    cmp_c = 1'b0;
    unique case (op)
      OP_ADD:     res_c = operand_a + operand_b;
      OP_SUB:     res_c = operand_a - operand_b;
      OP_MUL:     res_c = neg ? (~pmag + 1'b1) : pmag;
      OP_DIV:     res_c = '0;
      OP_INC:     res_c = operand_a + 1'b1;
      OP_DEC:     res_c = operand_a - 1'b1;
      OP_MIN:     res_c = (operand_a > operand_b) ? operand_b : operand_a;
      OP_MAX:     res_c = (operand_a < operand_b) ? operand_b : operand_a;
      OP_GT:      cmp_c = operand_a > operand_b;
      OP_LT:      cmp_c = operand_a < operand_b;
      OP_GE:      cmp_c = operand_a >= operand_b;
      OP_LE:      cmp_c = operand_a <= operand_b;
      OP_EQ:      cmp_c = operand_a == operand_b;
      OP_NE:      cmp_c = operand_a != operand_b;
      OP_TOINT:   res_c = operand_a >>> FracBits;
      OP_FROMINT: res_c = operand_a << FracBits;
      default:    res_c = '0;
    endcase
  end

  always_comb begin
    lane_next        = '0;
    lane_next.valid  = in_valid;
    lane_next.is_div = (op == OP_DIV) && (operand_b != '0);
    lane_next.dz     = (op == OP_DIV) && (operand_b == '0);
    lane_next.neg    = neg;
    lane_next.res    = res_c;
    lane_next.cmp    = cmp_c;
    lane_next.rem    = '0;
    lane_next.num    = {mag_a, {FracBits{1'b0}}};
    lane_next.den    = mag_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane.valid <= 1'b0;
    end else if (en) begin
      lane <= lane_next;
    end
  end

endmodule

@@ src/fxalu_cell.sv @@
// ----------------------------------------------------------------------------
// fxalu_cell
// One restoring-division step: shifts in a numerator bit, trial-subtracts,
// passes the beat on to the next cell.
// ----------------------------------------------------------------------------
module fxalu_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  fxalu_pkg::lane_t lane_in,
  output fxalu_pkg::lane_t lane_out
);
  import fxalu_pkg::*;

  logic [MagW:0]  trial;
  logic [MagW+1:0] diff;
  lane_t          lane_next;

  assign trial = {lane_in.rem[MagW-1:0], lane_in.num[QuotW-1]};
  assign diff  = {1'b0, trial} - {2'b00, lane_in.den};

  always_comb begin
    lane_next = lane_in;
    if (lane_in.is_div) begin
      lane_next.rem = diff[MagW+1] ? trial : diff[MagW:0];
      lane_next.num = {lane_in.num[QuotW-2:0], ~diff[MagW+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

@@ src/fixed_point_q24_8_alu_core.sv @@
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core
// Q24.8 fixed-point ALU with a row of restoring-division cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with operation, operand_a, operand_b.
//   Output channel: out_valid / out_stall with result, compare_true,
//   div_by_zero. A beat moves when valid is high and stall is low.
//   Every beat, for every operation, passes through one decode stage and
//   then a row of 40 division cells (one quotient bit each); one beat is
//   taken per cycle while in_stall is low.
//   The row advances as a whole: a beat may enter whenever the output
//   register is empty or being taken this cycle. When the receiver
//   stalls with a beat waiting at the end, the whole row holds and
//   in_stall rises.
//   Synchronous reset empties the row; no beat is in flight afterwards.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [3:0]                          operation,
  input  logic signed [fxalu_pkg::DataW-1:0]  operand_a,
  input  logic signed [fxalu_pkg::DataW-1:0]  operand_b,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fxalu_pkg::DataW-1:0]  result,
  output logic                                compare_true,
  output logic                                div_by_zero
);
  import fxalu_pkg::*;

  lane_t          row [NumCells+1];
  lane_t          last;
  logic           en;
  logic [DataW-1:0] qmag;

  assign last     = row[NumCells];
  assign en       = !(last.valid && out_stall);
  assign in_stall = !en;

  fxalu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .operation (operation),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .lane      (row[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    fxalu_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .lane_in  (row[i]),
      .lane_out (row[i+1])
    );
  end

  assign qmag         = last.num[DataW-1:0];
  assign out_valid    = last.valid;
  assign result       = last.is_div ? (last.neg ? (~qmag + 1'b1) : qmag) : last.res;
  assign compare_true = last.cmp;
  assign div_by_zero  = last.dz;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result))
    else $error("output beat changed under stall");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output back-pressure");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(compare_true && div_by_zero))
    else $error("compare and divide flags both set");
`endif

endmodule
